/* rtl/ltws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ltws_pkg;

   // default sizes of the time and sum datapaths
   localparam int TIME_WIDTH_DEF = 32;
   localparam int SUM_WIDTH_DEF  = 48;

   // fixed widths of the channel fields and the counters
   localparam int CMD_WIDTH   = 3;
   localparam int FIELD_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;

   // request command codes
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_CYCLE        = 3'd0,
      CMD_SONAR        = 3'd1,
      CMD_OVERRUN      = 3'd2,
      CMD_RESET_WINDOW = 3'd3,
      CMD_RESET_ALL    = 3'd4
   } cmd_type;

   // classified operation handed from the front to the back
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CYCLE,
      OP_SONAR,
      OP_OVERRUN,
      OP_CLR_WIN,
      OP_CLR_ALL
   } op_type;

   // back end sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOAD
   } state_type;

   // saturating increment of a counter
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      logic [COUNT_WIDTH-1:0] r;
      r = (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/ltws_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

// request channel: one event
interface ltws_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [31:0] interval;
   logic [31:0] duration;

   modport source (output valid, output command, output interval, output duration,
                   input ready);
   modport sink   (input valid, input command, input interval, input duration,
                   output ready);
endinterface

// response channel: one statistics snapshot
interface ltws_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] cycle_count;
   logic [31:0] overrun_count;
   logic [31:0] window_samples;
   logic [31:0] window_min_interval;
   logic [31:0] window_max_interval;
   logic [31:0] window_mean_interval;
   logic [31:0] window_max_duration;
   logic [31:0] window_max_sonar;

   modport source (output valid, output cycle_count, output overrun_count,
                   output window_samples, output window_min_interval,
                   output window_max_interval, output window_mean_interval,
                   output window_max_duration, output window_max_sonar,
                   input ready);
   modport sink   (input valid, input cycle_count, input overrun_count,
                   input window_samples, input window_min_interval,
                   input window_max_interval, input window_mean_interval,
                   input window_max_duration, input window_max_sonar,
                   output ready);
endinterface

`default_nettype wire

/* rtl/ltws_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module ltws_div
   import ltws_pkg::*;
#(
   parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SUM_WIDTH-1:0]   dividend,
   input  wire logic [COUNT_WIDTH-1:0] divisor,
   output logic                        done,
   output logic [SUM_WIDTH-1:0]        quotient
);

   localparam int CNT_W = $clog2(SUM_WIDTH + 1);

   logic [SUM_WIDTH-1:0]   dvd_ff, dvd_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   run_ff, run_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH:0]   shifted;
   logic [COUNT_WIDTH:0]   diff;

   // one restoring step: shift in the next dividend bit, try a subtract
   assign shifted = {rem_ff, dvd_ff[SUM_WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CNT_W'(SUM_WIDTH);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!diff[COUNT_WIDTH]) begin
            rem_in = diff[COUNT_WIDTH-1:0];
            dvd_in = {dvd_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[COUNT_WIDTH-1:0];
            dvd_in = {dvd_ff[SUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

/* rtl/ltws_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ltws_front
   import ltws_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ltws_req_if.sink                   req_ch,
   output logic                       op_valid,
   input  wire logic                  op_pop,
   output op_type                     op_kind,
   output logic [TIME_WIDTH-1:0]      op_dt,
   output logic [TIME_WIDTH-1:0]      op_dur
);

   op_type                kind_ff [2];
   logic [TIME_WIDTH-1:0] dt_ff   [2];
   logic [TIME_WIDTH-1:0] dur_ff  [2];
   logic [1:0]            cnt_ff, cnt_in;
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic                  push;
   op_type                kind_new;
   logic [TIME_WIDTH-1:0] dt_new;
   logic [TIME_WIDTH-1:0] dur_new;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;

   // time fields taken modulo the time width
   assign dt_new  = TIME_WIDTH'(req_ch.interval);
   assign dur_new = TIME_WIDTH'(req_ch.duration);

   // classify the request; a zero sonar time and unused codes do nothing
   always_comb begin
      case (cmd_type'(req_ch.command))
         CMD_CYCLE:        kind_new = OP_CYCLE;
         CMD_SONAR:        kind_new = (dur_new != '0) ? OP_SONAR : OP_NONE;
         CMD_OVERRUN:      kind_new = OP_OVERRUN;
         CMD_RESET_WINDOW: kind_new = OP_CLR_WIN;
         CMD_RESET_ALL:    kind_new = OP_CLR_ALL;
         default:          kind_new = OP_NONE;
      endcase
   end

   // two-entry queue toward the back end
   always_comb begin
      cnt_in    = cnt_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (op_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !op_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && op_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         kind_ff[wr_ptr_ff] <= kind_new;
         dt_ff[wr_ptr_ff]   <= dt_new;
         dur_ff[wr_ptr_ff]  <= dur_new;
      end
   end

   assign op_valid = (cnt_ff != 2'd0);
   assign op_kind  = kind_ff[rd_ptr_ff];
   assign op_dt    = dt_ff[rd_ptr_ff];
   assign op_dur   = dur_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/ltws_stats.sv */
`timescale 1ns / 1ps
`default_nettype none

module ltws_stats
   import ltws_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int SUM_WIDTH  = SUM_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  op_valid,
   output logic                       op_pop,
   input  wire op_type                op_kind,
   input  wire logic [TIME_WIDTH-1:0] op_dt,
   input  wire logic [TIME_WIDTH-1:0] op_dur,
   ltws_rsp_if.source                 rsp_ch
);

   localparam int AW = ((TIME_WIDTH > SUM_WIDTH) ? TIME_WIDTH : SUM_WIDTH) + 1;
   localparam int QW = (TIME_WIDTH > SUM_WIDTH) ? TIME_WIDTH : SUM_WIDTH;

   state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0] cycles_ff, cycles_in;
   logic [COUNT_WIDTH-1:0] overruns_ff, overruns_in;
   logic [COUNT_WIDTH-1:0] samples_ff, samples_in;
   logic [TIME_WIDTH-1:0]  min_ff, min_in;
   logic [TIME_WIDTH-1:0]  max_ff, max_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [TIME_WIDTH-1:0]  maxdur_ff, maxdur_in;
   logic [TIME_WIDTH-1:0]  sonar_ff, sonar_in;
   logic                   out_valid_ff, out_valid_in;
   logic [FIELD_WIDTH-1:0] o_cycles_ff, o_overruns_ff, o_samples_ff, o_min_ff;
   logic [FIELD_WIDTH-1:0] o_max_ff, o_mean_ff, o_maxdur_ff, o_sonar_ff;
   logic [AW-1:0]          sum_wide;
   logic [SUM_WIDTH-1:0]   sum_sat;
   logic [QW-1:0]          quot_ext;
   logic [TIME_WIDTH-1:0]  mean;
   logic [SUM_WIDTH-1:0]   quotient;
   logic                   div_start;
   logic                   div_done;
   logic                   out_free;
   logic                   load;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               state_in = (samples_in != '0) ? ST_DIV : ST_LOAD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      op_pop    = 1'b0;
      div_start = 1'b0;
      load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            op_pop    = op_valid;
            div_start = op_valid && (samples_in != '0);
         end
         ST_LOAD: load = out_free;
         default: ;
      endcase
   end

   // saturating interval sum
   assign sum_wide = AW'(sum_ff) + AW'(op_dt);
   assign sum_sat  = (sum_wide > AW'({SUM_WIDTH{1'b1}})) ? {SUM_WIDTH{1'b1}}
                                                         : SUM_WIDTH'(sum_wide);

   // statistics update on the popped operation
   always_comb begin
      cycles_in   = cycles_ff;
      overruns_in = overruns_ff;
      samples_in  = samples_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      sum_in      = sum_ff;
      maxdur_in   = maxdur_ff;
      sonar_in    = sonar_ff;
      if (op_pop) begin
         case (op_kind)
            OP_CYCLE: begin
               cycles_in  = sat_inc(cycles_ff);
               samples_in = sat_inc(samples_ff);
               sum_in     = sum_sat;
               if (op_dt < min_ff) min_in = op_dt;
               if (op_dt > max_ff) max_in = op_dt;
               if (op_dur > maxdur_ff) maxdur_in = op_dur;
            end
            OP_SONAR: begin
               if (op_dur > sonar_ff) sonar_in = op_dur;
            end
            OP_OVERRUN: overruns_in = sat_inc(overruns_ff);
            OP_CLR_WIN, OP_CLR_ALL: begin
               if (op_kind == OP_CLR_ALL) begin
                  cycles_in   = '0;
                  overruns_in = '0;
               end
               samples_in = '0;
               min_in     = '1;
               max_in     = '0;
               sum_in     = '0;
               maxdur_in  = '0;
               sonar_in   = '0;
            end
            default: ;
         endcase
      end
   end

   // mean from the divider, clamped to the time range
   assign quot_ext = QW'(quotient);
   assign mean     = (samples_ff == '0) ? '0
                   : (quot_ext > QW'({TIME_WIDTH{1'b1}})) ? {TIME_WIDTH{1'b1}}
                   : TIME_WIDTH'(quot_ext);

   assign out_valid_in = load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   ltws_div #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (samples_in),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer, figures and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cycles_ff    <= '0;
         overruns_ff  <= '0;
         samples_ff   <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         sum_ff       <= '0;
         maxdur_ff    <= '0;
         sonar_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cycles_ff    <= cycles_in;
         overruns_ff  <= overruns_in;
         samples_ff   <= samples_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         maxdur_ff    <= maxdur_in;
         sonar_ff     <= sonar_in;
      end
   end

   // response snapshot register
   always_ff @(posedge clock) begin
      if (load) begin
         o_cycles_ff   <= cycles_ff;
         o_overruns_ff <= overruns_ff;
         o_samples_ff  <= samples_ff;
         o_min_ff      <= (samples_ff == '0) ? '0 : FIELD_WIDTH'(min_ff);
         o_max_ff      <= FIELD_WIDTH'(max_ff);
         o_mean_ff     <= FIELD_WIDTH'(mean);
         o_maxdur_ff   <= FIELD_WIDTH'(maxdur_ff);
         o_sonar_ff    <= FIELD_WIDTH'(sonar_ff);
      end
   end

   assign rsp_ch.valid                = out_valid_ff;
   assign rsp_ch.cycle_count          = o_cycles_ff;
   assign rsp_ch.overrun_count        = o_overruns_ff;
   assign rsp_ch.window_samples       = o_samples_ff;
   assign rsp_ch.window_min_interval  = o_min_ff;
   assign rsp_ch.window_max_interval  = o_max_ff;
   assign rsp_ch.window_mean_interval = o_mean_ff;
   assign rsp_ch.window_max_duration  = o_maxdur_ff;
   assign rsp_ch.window_max_sonar     = o_sonar_ff;

endmodule

`default_nettype wire

/* rtl/loop_timing_window_stats.sv */
// Loop timing window statistics monitor.
// Requests arrive on req_ch (valid/ready): a command (loop cycle, sonar block,
// overrun, reset window, reset all) with an interval and a duration in us.
// Every request answers with one snapshot on rsp_ch (valid/ready): lifetime
// cycle and overrun counts plus window samples, min, max, mean interval,
// longest loop duration and longest sonar time.
// A two-entry queue sits behind req_ch, so requests are taken while the
// statistics engine is busy or a response waits.
// A request with a nonempty window leaves the queue, passes the divider (the
// mean is formed by a restoring divider, one quotient bit per cycle), then
// the snapshot is loaded; with an empty window the divider is skipped.
// The engine takes the next request from the queue only after it has loaded
// the snapshot for the previous one.
// Reset clears all counts and the window; min reads as 0 until a sample.
// When rsp_ch stalls the snapshot holds, the engine waits to load the next
// one, and req_ch.ready falls once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module loop_timing_window_stats
   import ltws_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEF,
   parameter int SUM_WIDTH  = SUM_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ltws_req_if.sink   req_ch,
   ltws_rsp_if.source rsp_ch
);

   logic                  op_valid;
   logic                  op_pop;
   op_type                op_kind;
   logic [TIME_WIDTH-1:0] op_dt;
   logic [TIME_WIDTH-1:0] op_dur;

   ltws_front #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .op_kind  (op_kind),
      .op_dt    (op_dt),
      .op_dur   (op_dur)
   );

   ltws_stats #(
      .TIME_WIDTH (TIME_WIDTH),
      .SUM_WIDTH  (SUM_WIDTH)
   ) u_stats (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_pop   (op_pop),
      .op_kind  (op_kind),
      .op_dt    (op_dt),
      .op_dur   (op_dur),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire
